/* rtl/ip_packet_class_and_trace_len_macros.svh */
// Assertion helpers for the packet classifier.
// Used by the top level only; no other dependencies.
`ifndef IP_PACKET_CLASS_AND_TRACE_LEN_MACROS_SVH
`define IP_PACKET_CLASS_AND_TRACE_LEN_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define PKC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pkc assertion failed");

// Check that cons holds in the cycle after ante.
`define PKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pkc assertion failed");

`endif

/* rtl/pkc_pkg.sv */
// Shared types, codes and helpers of the packet classifier.
// No dependencies; imported by the interfaces and all modules.
package pkc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned HLEN_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FRAG_W     = 13;

  localparam logic [PORT_W-1:0] FTP_PORT_RST = 16'd21;
  localparam logic [PORT_W-1:0] DNS_PORT_RST = 16'd53;

  localparam logic [3:0] VER_IPV4 = 4'd4;
  localparam logic [3:0] VER_IPV6 = 4'd6;

  localparam logic [BYTE_W-1:0] PROTO_ICMP   = 8'd1;
  localparam logic [BYTE_W-1:0] PROTO_TCP    = 8'd6;
  localparam logic [BYTE_W-1:0] PROTO_UDP    = 8'd17;
  localparam logic [BYTE_W-1:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [BYTE_W-1:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [BYTE_W-1:0] ICMP_ECHO_REP   = 8'd0;
  localparam logic [BYTE_W-1:0] ICMPV6_ECHO_REQ = 8'd128;
  localparam logic [BYTE_W-1:0] ICMPV6_ECHO_REP = 8'd129;

  localparam logic [5:0] TCP_FLAG_MASK = 6'h3F;
  localparam int unsigned TCP_SYN_BIT = 1;
  localparam int unsigned TCP_ACK_BIT = 4;

  localparam logic [HLEN_W-1:0] IPV6_HLEN = 6'd40;
  localparam logic [LEN_W-1:0]  L4_SHORT_HDR = 16'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FTP_PORT = 2'd0,
    CFG_DNS_PORT = 2'd1,
    CFG_PRIO_EN  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CLS_NULL      = 4'd0,
    CLS_TCP       = 4'd1,
    CLS_SYN       = 4'd2,
    CLS_ACK       = 4'd3,
    CLS_FTP       = 4'd4,
    CLS_UDP       = 4'd5,
    CLS_DNS       = 4'd6,
    CLS_ICMP      = 4'd7,
    CLS_USER_HIGH = 4'd8,
    CLS_INVALID   = 4'd9
  } data_class_e;

  // Header fields gathered for the decision on the last byte.
  typedef struct packed {
    logic [3:0]        ver;
    logic [HLEN_W-1:0] hlen;
    logic [BYTE_W-1:0] proto;
    logic              frag_zero;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
    logic [HLEN_W-1:0] tcp_hlen;
    logic [5:0]        tcp_flags;
    logic [BYTE_W-1:0] l4_type;
    logic [LEN_W-1:0]  pkt_len;
    logic              prio_tag;
  } pkc_hdr_t;

  // IP header length in bytes: IHL words for IPv4, fixed for IPv6, else zero.
  function automatic logic [HLEN_W-1:0] ip_head_len(input logic [BYTE_W-1:0] ver_ihl);
    logic [HLEN_W-1:0] hlen;
    hlen = '0;
    if (ver_ihl[7:4] == VER_IPV4) begin
      hlen = {ver_ihl[3:0], 2'b00};
    end else if (ver_ihl[7:4] == VER_IPV6) begin
      hlen = IPV6_HLEN;
    end
    return hlen;
  endfunction

endpackage

/* rtl/pkc_in_if.sv */
// Input channel of the packet classifier: one packet byte per item.
// Depends on pkc_pkg.
interface pkc_in_if import pkc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pkt_byte;
  logic              high_priority;
  logic              last_byte;

  modport source (output valid, output pkt_byte, output high_priority,
                  output last_byte, input ready);
  modport sink   (input valid, input pkt_byte, input high_priority,
                  input last_byte, output ready);
endinterface

/* rtl/pkc_out_if.sv */
// Output channel of the packet classifier: one class and trace length per item.
// Depends on pkc_pkg.
interface pkc_out_if import pkc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [3:0]       data_class;
  logic [LEN_W-1:0] trace_len;

  modport source (output valid, output data_class, output trace_len, input ready);
  modport sink   (input valid, input data_class, input trace_len, output ready);
endinterface

/* rtl/pkc_decide.sv */
// Classification and trace-length decision from gathered header fields.
// Depends on pkc_pkg.
module pkc_decide import pkc_pkg::*; (
  input  pkc_hdr_t          hdr_i,
  input  logic [PORT_W-1:0] ftp_port_i,
  input  logic [PORT_W-1:0] dns_port_i,
  input  logic              prio_en_i,
  output data_class_e       data_class_o,
  output logic [LEN_W-1:0]  trace_len_o
);

  logic [LEN_W-1:0] hlen_ext;
  logic [LEN_W-1:0] tcp_total;
  logic             bare_tcp;
  logic             ftp_dst;
  logic             ftp_any;
  logic             dns_dst;
  logic             dns_any;

  assign hlen_ext  = LEN_W'(hdr_i.hlen);
  assign tcp_total = hlen_ext + LEN_W'(hdr_i.tcp_hlen);
  assign bare_tcp  = (hdr_i.pkt_len == tcp_total);
  assign ftp_dst   = (hdr_i.dst_port == ftp_port_i);
  assign ftp_any   = ftp_dst || (hdr_i.src_port == ftp_port_i);
  assign dns_dst   = (hdr_i.dst_port == dns_port_i);
  assign dns_any   = dns_dst || (hdr_i.src_port == dns_port_i);

  // Pick class by protocol, then apply the priority override to a known version
  always_comb begin
    data_class_o = CLS_NULL;
    trace_len_o  = hlen_ext;
    if (hdr_i.ver != VER_IPV4 && hdr_i.ver != VER_IPV6) begin
      data_class_o = CLS_INVALID;
      trace_len_o  = '0;
    end else begin
      if (hdr_i.proto == PROTO_TCP) begin
        data_class_o = CLS_TCP;
        if (bare_tcp) begin
          if (hdr_i.tcp_flags[TCP_SYN_BIT]) begin
            data_class_o = CLS_SYN;
          end else if (hdr_i.tcp_flags[TCP_ACK_BIT]) begin
            data_class_o = CLS_ACK;
          end
          trace_len_o = hdr_i.pkt_len;
        end else begin
          if (ftp_dst) begin
            data_class_o = CLS_FTP;
          end
          trace_len_o = ftp_any ? hdr_i.pkt_len : tcp_total;
        end
      end else if (hdr_i.proto == PROTO_UDP) begin
        data_class_o = dns_dst ? CLS_DNS : CLS_UDP;
        trace_len_o  = dns_any ? hdr_i.pkt_len : hlen_ext + L4_SHORT_HDR;
      end else if (hdr_i.proto == PROTO_ICMP) begin
        if (hdr_i.frag_zero &&
            (hdr_i.l4_type == ICMP_ECHO_REQ || hdr_i.l4_type == ICMP_ECHO_REP)) begin
          data_class_o = CLS_ICMP;
        end
        trace_len_o = hlen_ext + L4_SHORT_HDR;
      end else if (hdr_i.proto == PROTO_ICMPV6) begin
        if (hdr_i.l4_type == ICMPV6_ECHO_REQ || hdr_i.l4_type == ICMPV6_ECHO_REP) begin
          data_class_o = CLS_ICMP;
        end
        trace_len_o = hlen_ext + L4_SHORT_HDR;
      end
      if (prio_en_i && hdr_i.prio_tag) begin
        data_class_o = CLS_USER_HIGH;
      end
    end
  end

endmodule

/* rtl/ip_packet_class_and_trace_len.sv */
// IP packet classifier with privacy-safe trace length.
// Takes one packet byte per input item, starting at IP header byte 0; last_byte
// ends the packet and high_priority is sampled on the first byte. For each packet
// one result item leaves on the output channel: a traffic class and the number of
// leading bytes that may be traced without exposing payload.
// Latency: the result is valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle, save for a last byte held by the stall below;
// header capture and the final decision are combinational, feeding the result register.
// Stall: while a result waits in the result register, bytes that are not the
// last of a packet are still taken; a last byte waits until the result leaves.
// Reset clears the byte counter, the result valid and the configuration
// (ftp_port 21, dns_port 53, override off). Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only while no packet is
// in flight, which the block does not enforce; an index outside the register list is ignored.
// Depends on pkc_pkg, pkc_in_if, pkc_out_if, pkc_decide and the macro header.
module ip_packet_class_and_trace_len import pkc_pkg::*; #(
  parameter int unsigned L4_WINDOW  = 14,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pkc_in_if.sink                in_i,
  pkc_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] PosVerIpv6Proto = COUNT_BITS'(6);
  localparam logic [COUNT_BITS-1:0] PosVerIpv4Proto = COUNT_BITS'(9);
  localparam logic [COUNT_BITS-1:0] PosFragHi = COUNT_BITS'(6);
  localparam logic [COUNT_BITS-1:0] PosFragLo = COUNT_BITS'(7);

  // Configuration registers
  logic [PORT_W-1:0] ftp_port_q;
  logic [PORT_W-1:0] dns_port_q;
  logic              prio_en_q;

  // Packet state
  logic [COUNT_BITS-1:0] byte_count_q, byte_count_d;
  logic [BYTE_W-1:0]     ver_ihl_q, ver_ihl_d;
  logic [BYTE_W-1:0]     proto_q, proto_d;
  logic [FRAG_W-1:0]     frag_q, frag_d;
  logic [BYTE_W-1:0]     l4_q [L4_WINDOW];
  logic [BYTE_W-1:0]     l4_d [L4_WINDOW];
  logic                  tag_q, tag_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  data_class_e      class_q;
  logic [LEN_W-1:0] trace_q;

  logic              in_acc;
  logic              first;
  logic [HLEN_W-1:0] hlen;
  logic [3:0]        ver;
  logic              proto_cap;
  logic [COUNT_BITS-1:0] pkt_len;
  pkc_hdr_t          hdr;
  data_class_e       class_d;
  logic [LEN_W-1:0]  trace_d;

  // Take a byte unless it would finish a packet while the result is stuck
  assign in_i.ready = !out_valid_q || out_o.ready || !in_i.last_byte;
  assign in_acc     = in_i.valid && in_i.ready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ftp_port_q <= FTP_PORT_RST;
      dns_port_q <= DNS_PORT_RST;
      prio_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FTP_PORT: ftp_port_q <= cfg_data_i[PORT_W-1:0];
        CFG_DNS_PORT: dns_port_q <= cfg_data_i[PORT_W-1:0];
        CFG_PRIO_EN:  prio_en_q  <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // Capture header fields of the current byte
  assign first     = (byte_count_q == '0);
  assign ver_ihl_d = first ? in_i.pkt_byte : ver_ihl_q;
  assign ver       = ver_ihl_d[7:4];
  assign hlen      = ip_head_len(ver_ihl_d);
  assign tag_d     = first ? in_i.high_priority : tag_q;
  assign proto_cap = (ver == VER_IPV4 && byte_count_q == PosVerIpv4Proto) ||
                     (ver == VER_IPV6 && byte_count_q == PosVerIpv6Proto);
  assign proto_d   = proto_cap ? in_i.pkt_byte : (first ? '0 : proto_q);

  always_comb begin
    frag_d = first ? '0 : frag_q;
    if (byte_count_q == PosFragHi) begin
      frag_d[FRAG_W-1:BYTE_W] = in_i.pkt_byte[FRAG_W-BYTE_W-1:0];
    end
    if (byte_count_q == PosFragLo) begin
      frag_d[BYTE_W-1:0] = in_i.pkt_byte;
    end
  end

  // Fill the layer-4 window; clear it on the first byte of a packet
  for (genvar i = 0; i < L4_WINDOW; i++) begin : g_l4
    assign l4_d[i] = (byte_count_q == COUNT_BITS'(hlen) + COUNT_BITS'(i)) ? in_i.pkt_byte :
                     (first ? '0 : l4_q[i]);
  end

  // Saturating packet length including this byte
  assign pkt_len      = (byte_count_q < CountMax) ? byte_count_q + CountOne : CountMax;
  assign byte_count_d = in_i.last_byte ? '0 : pkt_len;

  // Gather decision inputs
  always_comb begin
    hdr.ver       = ver;
    hdr.hlen      = hlen;
    hdr.proto     = proto_d;
    hdr.frag_zero = (frag_d == '0);
    hdr.src_port  = {l4_d[0], l4_d[1]};
    hdr.dst_port  = {l4_d[2], l4_d[3]};
    hdr.tcp_hlen  = {l4_d[12][7:4], 2'b00};
    hdr.tcp_flags = l4_d[13][5:0] & TCP_FLAG_MASK;
    hdr.l4_type   = l4_d[0];
    hdr.pkt_len   = LEN_W'(pkt_len);
    hdr.prio_tag  = tag_d;
  end

  pkc_decide u_decide (
    .hdr_i        (hdr),
    .ftp_port_i   (ftp_port_q),
    .dns_port_i   (dns_port_q),
    .prio_en_i    (prio_en_q),
    .data_class_o (class_d),
    .trace_len_o  (trace_d)
  );

  // Advance the byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else if (in_acc) begin
      byte_count_q <= byte_count_d;
    end
  end

  // Hold header fields of the packet in flight
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ver_ihl_q <= ver_ihl_d;
      proto_q   <= proto_d;
      frag_q    <= frag_d;
      tag_q     <= tag_d;
      l4_q      <= l4_d;
    end
  end

  // Load the result on the last byte, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc && in_i.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.last_byte) begin
      class_q <= class_d;
      trace_q <= trace_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_class = class_q;
  assign out_o.trace_len  = trace_q;

  // Checks
`include "ip_packet_class_and_trace_len_macros.svh"

  `PKC_ASSERT_SAME(a_result_from_last, clk_i, rst_ni, $rose(out_valid_q), $past(in_acc && in_i.last_byte))
  `PKC_ASSERT_NEXT(a_count_restart, clk_i, rst_ni, in_acc && in_i.last_byte, byte_count_q == '0)
  `PKC_ASSERT_SAME(a_invalid_no_trace, clk_i, rst_ni, out_valid_q && class_q == CLS_INVALID, trace_q == '0)

endmodule

/* dv/tb_ip_packet_class_and_trace_len.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the IP packet classifier: packets go in byte by byte, and each
// class and trace length that comes out is checked against an in-bench prediction.
// Depends on pkc_pkg, pkc_in_if, pkc_out_if and ip_packet_class_and_trace_len.
module tb_ip_packet_class_and_trace_len;
  import pkc_pkg::*;

  localparam int unsigned L4_WIN      = 14;
  localparam int unsigned CNT_BITS    = 16;
  localparam int unsigned CNT_MAX     = (1 << CNT_BITS) - 1;
  localparam int unsigned PHASE_ITEMS = 350;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              hp;
    logic              last;
    int unsigned       gap;
  } pkt_item_t;

  typedef struct {
    data_class_e      cls;
    logic [LEN_W-1:0] trace;
  } class_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pkc_in_if  in_if();
  pkc_out_if out_if();

  ip_packet_class_and_trace_len #(
    .L4_WINDOW (L4_WIN),
    .COUNT_BITS(CNT_BITS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted classifier state and configuration
  logic [PORT_W-1:0] cfg_ftp;
  logic [PORT_W-1:0] cfg_dns;
  logic              cfg_prio;
  int unsigned       byte_pos;
  logic [BYTE_W-1:0] ver_ihl;
  logic [BYTE_W-1:0] proto;
  logic [15:0]       frag_word;
  logic [BYTE_W-1:0] l4_hdr [L4_WIN];
  logic              prio_tag;

  // Stimulus and scoreboard stores
  pkt_item_t   pending_bytes [$];
  class_res_t  expected_res [$];
  logic [7:0]  pkt [$];
  pkt_item_t   cur_item;
  logic        offering = 1'b0;
  logic        fire_in = 1'b0;
  int unsigned n_queued = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  int unsigned in_gap_pct = 0;
  int unsigned pkt_epoch = 0;
  int unsigned out_stall_pct = 0;
  int unsigned out_epoch = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        pressure_done = 1'b0;

  // Short gaps mostly, a long one now and then
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Idle rate of one stretch: none, light or heavy
  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // Advance the predicted state by one byte; on the last byte produce the result
  function automatic void classify_byte(input logic [BYTE_W-1:0] b, input logic hp,
                                        input logic last, output logic done,
                                        output class_res_t res);
    logic [3:0]        ver;
    int unsigned       pos, hl, len, tcp_hl;
    logic [PORT_W-1:0] src, dst;
    logic [5:0]        flags;
    pos  = byte_pos;
    done = 1'b0;
    res  = '{CLS_NULL, '0};
    if (pos == 0) begin
      ver_ihl   = b;
      proto     = '0;
      frag_word = '0;
      prio_tag  = hp;
      foreach (l4_hdr[i]) l4_hdr[i] = '0;
    end
    ver = ver_ihl[7:4];
    hl  = (ver == VER_IPV4) ? 4 * ver_ihl[3:0] : (ver == VER_IPV6) ? 40 : 0;
    if ((ver == VER_IPV4 && pos == 9) || (ver == VER_IPV6 && pos == 6)) proto = b;
    if (pos == 6) frag_word[15:8] = b;
    if (pos == 7) frag_word[7:0] = b;
    if (pos >= hl && pos - hl < L4_WIN) l4_hdr[pos - hl] = b;
    len = (pos < CNT_MAX) ? pos + 1 : CNT_MAX;
    if (!last) begin
      byte_pos = len;
      return;
    end
    byte_pos = 0;
    done     = 1'b1;

    // Unknown version: no trace at all, override does not apply
    if (ver != VER_IPV4 && ver != VER_IPV6) begin
      res.cls   = CLS_INVALID;
      res.trace = '0;
      return;
    end
    src       = {l4_hdr[0], l4_hdr[1]};
    dst       = {l4_hdr[2], l4_hdr[3]};
    res.trace = LEN_W'(hl);
    if (proto == PROTO_TCP) begin
      tcp_hl  = 4 * l4_hdr[12][7:4];
      res.cls = CLS_TCP;
      // Header-only segment: SYN beats ACK, trace all of it
      if (len == hl + tcp_hl) begin
        flags = l4_hdr[13][5:0] & TCP_FLAG_MASK;
        if (flags[TCP_SYN_BIT]) begin
          res.cls = CLS_SYN;
        end else if (flags[TCP_ACK_BIT]) begin
          res.cls = CLS_ACK;
        end
        res.trace = LEN_W'(len);
      end else begin
        if (dst == cfg_ftp) res.cls = CLS_FTP;
        res.trace = (src == cfg_ftp || dst == cfg_ftp) ? LEN_W'(len) : LEN_W'(hl + tcp_hl);
      end
    end else if (proto == PROTO_UDP) begin
      res.cls   = (dst == cfg_dns) ? CLS_DNS : CLS_UDP;
      res.trace = (src == cfg_dns || dst == cfg_dns) ? LEN_W'(len) : LEN_W'(hl + 8);
    end else if (proto == PROTO_ICMP) begin
      // Echo only counts on an unfragmented packet
      if (frag_word[12:0] == '0 && (l4_hdr[0] == ICMP_ECHO_REQ || l4_hdr[0] == ICMP_ECHO_REP))
        res.cls = CLS_ICMP;
      res.trace = LEN_W'(hl + 8);
    end else if (proto == PROTO_ICMPV6) begin
      if (l4_hdr[0] == ICMPV6_ECHO_REQ || l4_hdr[0] == ICMPV6_ECHO_REP) res.cls = CLS_ICMP;
      res.trace = LEN_W'(hl + 8);
    end
    if (cfg_prio && prio_tag) res.cls = CLS_USER_HIGH;
  endfunction

  // Check results, track config writes, predict on every accepted byte
  always @(posedge clk_i) begin
    class_res_t want;
    class_res_t res;
    logic       done;
    if (!rst_ni) begin
      fire_in   <= 1'b0;
      cfg_ftp   = FTP_PORT_RST;
      cfg_dns   = DNS_PORT_RST;
      cfg_prio  = 1'b0;
      byte_pos  = 0;
      ver_ihl   = '0;
      proto     = '0;
      frag_word = '0;
      prio_tag  = 1'b0;
      foreach (l4_hdr[i]) l4_hdr[i] = '0;
    end else begin
      fire_in <= in_if.valid && in_if.ready;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FTP_PORT: cfg_ftp = cfg_data;
          CFG_DNS_PORT: cfg_dns = cfg_data;
          CFG_PRIO_EN:  cfg_prio = cfg_data[0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (expected_res.size() == 0) begin
          $display("%0t: result with none expected: class %0d trace %0d",
                   $time, out_if.data_class, out_if.trace_len);
          n_errors++;
        end else begin
          want = expected_res.pop_front();
          if (out_if.data_class !== want.cls) begin
            $display("%0t: data_class expected %0d actual %0d",
                     $time, want.cls, out_if.data_class);
            n_errors++;
          end
          if (out_if.trace_len !== want.trace) begin
            $display("%0t: trace_len expected %0d actual %0d",
                     $time, want.trace, out_if.trace_len);
            n_errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        classify_byte(in_if.pkt_byte, in_if.high_priority, in_if.last_byte, done, res);
        if (done) expected_res.push_back(res);
      end
    end
  end

  // Byte driver: hold each item until taken, honor its leading gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (offering && fire_in) offering = 1'b0;
      if (!offering && pending_bytes.size() != 0) begin
        if (pending_bytes[0].gap != 0) begin
          pending_bytes[0].gap = pending_bytes[0].gap - 1;
        end else begin
          cur_item = pending_bytes.pop_front();
          offering = 1'b1;
        end
      end
      in_if.valid         <= offering;
      in_if.pkt_byte      <= cur_item.b;
      in_if.high_priority <= cur_item.hp;
      in_if.last_byte     <= cur_item.last;
    end
  end

  // Result receiver: random stalls in stretches, plus one long hold-off
  always @(negedge clk_i) begin
    logic rdy;
    if (out_epoch == 0) begin
      out_epoch     = 256;
      out_stall_pct = pick_pct();
    end
    out_epoch--;
    if (!pressure_done && n_results >= 20) begin
      hold_left     = HOLD_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left = gap_len() - 1;
      rdy        = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_if.ready <= rdy && rst_ni;
  end

  // End the run if it hangs
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Overwrite a byte of the packet under construction if it is long enough
  function automatic void set_byte(input int unsigned idx, input logic [7:0] val);
    if (idx < pkt.size()) pkt[idx] = val;
  endfunction

  // Turn the packet under construction into items; the tag only matters on the first byte
  function automatic void queue_packet(input logic hp, input logic gaps_on);
    pkt_item_t it;
    if (pkt_epoch == 0) begin
      pkt_epoch  = 6;
      in_gap_pct = pick_pct();
    end
    pkt_epoch--;
    foreach (pkt[i]) begin
      it.b    = pkt[i];
      it.hp   = (i == 0) ? hp : 1'($urandom);
      it.last = (i == pkt.size() - 1);
      it.gap  = (gaps_on && $urandom_range(0, 99) < in_gap_pct) ? gap_len() : 0;
      pending_bytes.push_back(it);
    end
    n_queued += pkt.size();
  endfunction

  // Half the time a configured port, so FTP and DNS matches happen often
  function automatic logic [PORT_W-1:0] pick_port();
    case ($urandom_range(0, 9))
      0, 1, 2: return cfg_ftp;
      3, 4:    return cfg_dns;
      default: return PORT_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed IPv4/IPv6 packets with random content, some noise
  function automatic void queue_random_packet();
    logic [3:0]  ver, ihl, off;
    logic [7:0]  prot, icmp_type;
    logic [15:0] sport, dport, frag;
    int unsigned hl, n, sel;
    sel = $urandom_range(0, 9);
    ver = (sel < 8) ? VER_IPV4 : (sel == 8) ? VER_IPV6 : 4'($urandom);
    ihl = ($urandom_range(0, 9) < 8) ? 4'd5 : 4'($urandom);
    hl  = (ver == VER_IPV4) ? 4 * ihl : (ver == VER_IPV6) ? 40 : 0;
    sel = $urandom_range(0, 19);
    prot = (sel < 7) ? PROTO_TCP : (sel < 13) ? PROTO_UDP : (sel < 15) ? PROTO_ICMP :
           (sel < 17) ? PROTO_ICMPV6 : 8'($urandom);
    sport = pick_port();
    dport = pick_port();
    case ($urandom_range(0, 4))
      0: icmp_type = ICMP_ECHO_REQ;
      1: icmp_type = ICMP_ECHO_REP;
      2: icmp_type = ICMPV6_ECHO_REQ;
      3: icmp_type = ICMPV6_ECHO_REP;
      default: icmp_type = 8'($urandom);
    endcase
    if (prot == PROTO_ICMP || prot == PROTO_ICMPV6) sport[15:8] = icmp_type;
    off  = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom);
    frag = ($urandom_range(0, 1) != 0) ? {3'($urandom), 13'd0} : 16'($urandom);
    // Length: header-only TCP, truncated, or header plus a little payload
    sel = $urandom_range(0, 9);
    if (prot == PROTO_TCP && sel < 4) begin
      n = hl + 4 * off;
    end else if (sel < 6) begin
      n = $urandom_range(1, hl + 16);
    end else begin
      n = hl + $urandom_range(0, 24);
    end
    if (n == 0) n = 1;
    pkt = {};
    repeat (n) pkt.push_back(8'($urandom));
    set_byte(0, {ver, ihl});
    set_byte(6, frag[15:8]);
    set_byte(7, frag[7:0]);
    set_byte((ver == VER_IPV6) ? 6 : 9, prot);
    set_byte(hl, sport[15:8]);
    set_byte(hl + 1, sport[7:0]);
    set_byte(hl + 2, dport[15:8]);
    set_byte(hl + 3, dport[7:0]);
    set_byte(hl + 12, {off, 4'($urandom)});
    queue_packet(1'($urandom), 1'b1);
  endfunction

  function automatic void queue_random_items(input int unsigned count);
    int unsigned start;
    start = n_queued;
    while (n_queued - start < count) queue_random_packet();
  endfunction

  // Wait until every byte is taken and every result checked, then let the block settle
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || offering || expected_res.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write all three registers back to back while the block is idle
  task automatic apply_cfg(input logic [PORT_W-1:0] ftp, input logic [PORT_W-1:0] dns,
                           input logic prio);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FTP_PORT;
    cfg_data <= ftp;
    @(negedge clk_i);
    cfg_idx  <= CFG_DNS_PORT;
    cfg_data <= dns;
    @(negedge clk_i);
    cfg_idx  <= CFG_PRIO_EN;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, prio};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_FTP_PORT;
    cfg_data            = '0;
    cur_item            = '{8'h00, 1'b0, 1'b0, 0};
    in_if.valid         = 1'b0;
    in_if.pkt_byte      = '0;
    in_if.high_priority = 1'b0;
    in_if.last_byte     = 1'b0;
    out_if.ready        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-byte packets: bad versions, and headers cut off right after the first byte
    pkt = {8'h00};
    queue_packet(1'b0, 1'b1);
    pkt = {8'hFF};
    queue_packet(1'b1, 1'b1);
    pkt = {8'h45};
    queue_packet(1'b0, 1'b1);
    pkt = {8'h6F};
    queue_packet(1'b1, 1'b1);
    // IHL of zero: the layer-4 window starts at byte 0, destination port 53 in bytes 2..3
    pkt = {8'h40, 8'h00, 8'h00, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, PROTO_UDP};
    queue_packet(1'b0, 1'b1);
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    apply_cfg('0, '0, 1'b1);
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    apply_cfg('1, '1, 1'b1);
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    apply_cfg(PORT_W'($urandom), PORT_W'($urandom), 1'b0);
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    // Back to the reset ports for a last stretch
    apply_cfg(FTP_PORT_RST, DNS_PORT_RST, 1'b0);
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pkc_pkg.sv
rtl/pkc_in_if.sv
rtl/pkc_out_if.sv
rtl/pkc_decide.sv
rtl/ip_packet_class_and_trace_len.sv
dv/tb_ip_packet_class_and_trace_len.sv
